[rtl/kdvfv_pkg.sv]
// shared constants, types and codes for the kdv finite volume sweep block
// no dependencies; every other file of the block uses this package

package kdvfv_pkg;

  // grid geometry
  localparam int MAX_POINTS = 4096;
  localparam int MIN_POINTS = 6;
  localparam int POS_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = POS_W + 1;
  localparam int GP_W       = 13;
  localparam int IDX_W      = 12;
  localparam int FIRST_POS  = 4;

  // fixed point data
  localparam int DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COURANT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPERSION  = 3'd3;

  localparam logic [GP_W-1:0]   RST_GRID_POINTS = 13'd201;
  localparam logic [DATA_W-1:0] RST_COURANT     = 32'd32768;
  localparam logic [DATA_W-1:0] RST_DIFFUSION   = 32'd65536;
  localparam logic [DATA_W-1:0] RST_DISPERSION  = 32'd327680000;

  // datapath widths
  localparam int S2_W   = DATA_W + 2;   // second difference
  localparam int D3_W   = DATA_W + 4;   // third difference
  localparam int MA_W   = 37;           // multiplier operand a, signed
  localparam int MB_W   = DATA_W + 1;   // multiplier operand b, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int G_W    = 70;           // flux difference accumulator
  localparam int GLO_W  = 35;           // low slice of flux difference
  localparam int ACC_W  = 110;          // result accumulator

  // scaling shifts
  localparam int SH_DIFF = 2;
  localparam int SH_DISP = 18;
  localparam int SH_GHI  = GLO_W;
  localparam int SH_OUT  = 34;

  // multiply-accumulate sequence length
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef struct packed {
    logic [GP_W-1:0]   grid_points;
    logic [DATA_W-1:0] courant_ratio;
    logic [DATA_W-1:0] diffusion_coeff;
    logic [DATA_W-1:0] dispersion_coeff;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_UP_SQ,
    MUL_UM1_SQ,
    MUL_K_S2,
    MUL_D_D3,
    MUL_C_GLO,
    MUL_C_GHI
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_G_ADD,
    ACC_G_SUB,
    ACC_G_SUB4,
    ACC_T_SUB_DISP,
    ACC_T_SUB_GLO,
    ACC_T_SUB_GHI
  } acc_op_e;

  typedef enum logic {
    VAL_RESULT,
    VAL_SAMPLE
  } val_sel_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     finish;
    val_sel_e val_sel;
  } dp_cmd_t;

endpackage

[rtl/kdvfv_if.sv]
// valid/ready channel interfaces for grid samples in and updated points out
// depends on kdvfv_pkg for field widths

interface kdvfv_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [kdvfv_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface kdvfv_out_if;
  logic                               valid;
  logic                               ready;
  logic [kdvfv_pkg::IDX_W-1:0]        point_index;
  logic signed [kdvfv_pkg::DATA_W-1:0] new_value;
  logic                               sweep_end;

  modport source (output valid, output point_index, output new_value, output sweep_end,
                  input ready);
  modport sink   (input valid, input point_index, input new_value, input sweep_end,
                  output ready);
endinterface

[rtl/kdvfv_cfg.sv]
// configuration register file: grid size and the three Q16.16 coefficients
// depends on kdvfv_pkg

module kdvfv_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kdvfv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kdvfv_pkg::DATA_W-1:0]       cfg_data_i,
  output kdvfv_pkg::cfg_t                    cfg_o
);
  import kdvfv_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_points      <= RST_GRID_POINTS;
      cfg_q.courant_ratio    <= RST_COURANT;
      cfg_q.diffusion_coeff  <= RST_DIFFUSION;
      cfg_q.dispersion_coeff <= RST_DISPERSION;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_POINTS: cfg_q.grid_points      <= cfg_data_i[GP_W-1:0];
        CFG_COURANT:     cfg_q.courant_ratio    <= cfg_data_i;
        CFG_DIFFUSION:   cfg_q.diffusion_coeff  <= cfg_data_i;
        CFG_DISPERSION:  cfg_q.dispersion_coeff <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/kdvfv_dp.sv]
// datapath: sample window, shared multiplier, flux and result accumulators,
// rounding and saturation; depends on kdvfv_pkg

module kdvfv_dp (
  input  logic                               clk_i,
  input  kdvfv_pkg::cfg_t                    cfg_i,
  input  kdvfv_pkg::dp_cmd_t                 cmd_i,
  input  logic signed [kdvfv_pkg::DATA_W-1:0] sample_i,
  output logic signed [kdvfv_pkg::DATA_W-1:0] value_o
);
  import kdvfv_pkg::*;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (SH_OUT - 1));

  logic signed [DATA_W-1:0] win_q [4];
  logic signed [S2_W-1:0]   s2_q, s2_d;
  logic signed [D3_W-1:0]   d3_q, d3_d;
  logic signed [G_W-1:0]    g_q;
  logic signed [ACC_W-1:0]  t_q, t_init;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] res_q, res_d;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [G_W-1:0]    prod_g;
  logic signed [S2_W-1:0]   s_e2, w0_e2, w1_e2;
  logic signed [D3_W-1:0]   w0_e4, w1_e4, w2_e4, w3_e4;
  logic [ACC_W-1:SH_OUT+DATA_W-1] t_top;

  // differences of the new sample against the old window
  always_comb begin
    s_e2   = {{2{sample_i[DATA_W-1]}}, sample_i};
    w0_e2  = {{2{win_q[0][DATA_W-1]}}, win_q[0]};
    w1_e2  = {{2{win_q[1][DATA_W-1]}}, win_q[1]};
    w0_e4  = {{4{win_q[0][DATA_W-1]}}, win_q[0]};
    w1_e4  = {{4{win_q[1][DATA_W-1]}}, win_q[1]};
    w2_e4  = {{4{win_q[2][DATA_W-1]}}, win_q[2]};
    w3_e4  = {{4{win_q[3][DATA_W-1]}}, win_q[3]};
    s2_d   = s_e2 - (w0_e2 <<< 1) + w1_e2;
    d3_d   = w0_e4 - ((w1_e4 <<< 1) + w1_e4) + ((w2_e4 <<< 1) + w2_e4) - w3_e4;
    t_init = ({{(ACC_W-DATA_W){win_q[0][DATA_W-1]}}, win_q[0]} <<< SH_OUT) + ROUND_BIAS;
  end

  // multiplier operand selection; after the load the window holds
  // u[j+1], u[j], u[j-1], u[j-2] newest first
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_UP_SQ: begin
        mul_a = {{(MA_W-DATA_W){win_q[0][DATA_W-1]}}, win_q[0]};
        mul_b = {win_q[0][DATA_W-1], win_q[0]};
      end
      MUL_UM1_SQ: begin
        mul_a = {{(MA_W-DATA_W){win_q[2][DATA_W-1]}}, win_q[2]};
        mul_b = {win_q[2][DATA_W-1], win_q[2]};
      end
      MUL_K_S2: begin
        mul_a = {{(MA_W-S2_W){s2_q[S2_W-1]}}, s2_q};
        mul_b = {1'b0, cfg_i.diffusion_coeff};
      end
      MUL_D_D3: begin
        mul_a = {{(MA_W-D3_W){d3_q[D3_W-1]}}, d3_q};
        mul_b = {1'b0, cfg_i.dispersion_coeff};
      end
      MUL_C_GLO: begin
        mul_a = {{(MA_W-GLO_W){1'b0}}, g_q[GLO_W-1:0]};
        mul_b = {1'b0, cfg_i.courant_ratio};
      end
      MUL_C_GHI: begin
        mul_a = {{(MA_W-(G_W-GLO_W)){g_q[G_W-1]}}, g_q[G_W-1:GLO_W]};
        mul_b = {1'b0, cfg_i.courant_ratio};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d   = mul_a * mul_b;
    prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    prod_g   = prod_q[G_W-1:0];
  end

  // round, shift down and saturate to 32 bits
  always_comb begin
    t_top = t_q[ACC_W-1:SH_OUT+DATA_W-1];
    if ((&t_top) || !(|t_top)) begin
      res_d = t_q[SH_OUT+DATA_W-1:SH_OUT];
    end else if (t_q[ACC_W-1]) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // window, differences, product and accumulators
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      win_q[3] <= win_q[2];
      win_q[2] <= win_q[1];
      win_q[1] <= win_q[0];
      win_q[0] <= sample_i;
      s2_q     <= s2_d;
      d3_q     <= d3_d;
      t_q      <= t_init;
      g_q      <= '0;
    end else begin
      case (cmd_i.acc_op)
        ACC_G_ADD:      g_q <= g_q + prod_g;
        ACC_G_SUB:      g_q <= g_q - prod_g;
        ACC_G_SUB4:     g_q <= g_q - (prod_g <<< SH_DIFF);
        ACC_T_SUB_DISP: t_q <= t_q - (prod_ext <<< SH_DISP);
        ACC_T_SUB_GLO:  t_q <= t_q - prod_ext;
        ACC_T_SUB_GHI:  t_q <= t_q - (prod_ext <<< SH_GHI);
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  // boundary points carry the old last sample
  assign value_o = (cmd_i.val_sel == VAL_SAMPLE) ? win_q[0] : res_q;

endmodule

[rtl/kdvfv_ctrl.sv]
// controller: grid position, multiply-accumulate sequencing and result emission
// depends on kdvfv_pkg

module kdvfv_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kdvfv_pkg::GP_W-1:0]    grid_points_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kdvfv_pkg::IDX_W-1:0]   point_index_o,
  output logic                          sweep_end_o,
  output kdvfv_pkg::dp_cmd_t            cmd_o
);
  import kdvfv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FIN,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [POS_W-1:0] pos_q;
  logic [STEP_W-1:0] step_q;
  logic [2:0]       emit_q;
  logic             last_q;
  logic [IDX_W-1:0] idx_q;
  logic             end_q;
  val_sel_e         sel_q;

  logic [CNT_W-1:0] n;
  logic             last;
  logic             in_fire;
  logic             out_fire;

  // clamped grid size and end-of-sweep test
  always_comb begin
    if (grid_points_i < GP_W'(MIN_POINTS)) begin
      n = CNT_W'(MIN_POINTS);
    end else if (32'(grid_points_i) > 32'(MAX_POINTS)) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(grid_points_i);
    end
    last     = {1'b0, pos_q} >= (n - CNT_W'(1));
    in_fire  = in_valid_i && in_ready_o;
    out_fire = out_valid_o && out_ready_i;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_EMIT);
  assign point_index_o = idx_q;
  assign sweep_end_o   = end_q;

  // datapath command for the current step
  always_comb begin
    cmd_o.load    = in_fire;
    cmd_o.mul_sel = MUL_UP_SQ;
    cmd_o.acc_op  = ACC_NONE;
    cmd_o.finish  = (state_q == S_FIN);
    cmd_o.val_sel = sel_q;
    if (state_q == S_CALC) begin
      unique case (step_q)
        3'd0: begin
          cmd_o.mul_sel = MUL_UP_SQ;
          cmd_o.acc_op  = ACC_NONE;
        end
        3'd1: begin
          cmd_o.mul_sel = MUL_UM1_SQ;
          cmd_o.acc_op  = ACC_G_ADD;
        end
        3'd2: begin
          cmd_o.mul_sel = MUL_K_S2;
          cmd_o.acc_op  = ACC_G_SUB;
        end
        3'd3: begin
          cmd_o.mul_sel = MUL_D_D3;
          cmd_o.acc_op  = ACC_G_SUB4;
        end
        3'd4: begin
          cmd_o.mul_sel = MUL_C_GLO;
          cmd_o.acc_op  = ACC_T_SUB_DISP;
        end
        3'd5: begin
          cmd_o.mul_sel = MUL_C_GHI;
          cmd_o.acc_op  = ACC_T_SUB_GLO;
        end
        3'd6: begin
          cmd_o.mul_sel = MUL_C_GHI;
          cmd_o.acc_op  = ACC_T_SUB_GHI;
        end
        default: begin
          cmd_o.mul_sel = MUL_UP_SQ;
          cmd_o.acc_op  = ACC_NONE;
        end
      endcase
    end
  end

  // state, position and result labels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      step_q  <= '0;
      emit_q  <= '0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      end_q   <= 1'b0;
      sel_q   <= VAL_RESULT;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pos_q <= last ? '0 : pos_q + POS_W'(1);
            if (pos_q >= POS_W'(FIRST_POS)) begin
              last_q  <= last;
              idx_q   <= last ? IDX_W'(n - CNT_W'(2)) : IDX_W'(pos_q - POS_W'(1));
              end_q   <= 1'b0;
              sel_q   <= VAL_RESULT;
              emit_q  <= '0;
              step_q  <= '0;
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_fire) begin
            if (!last_q || end_q) begin
              state_q <= S_IDLE;
            end else begin
              emit_q <= emit_q + 3'd1;
              // end of sweep: copy of the last interior point, then boundary
              case (emit_q)
                3'd0: begin
                  idx_q <= idx_q + IDX_W'(1);
                  sel_q <= VAL_RESULT;
                end
                3'd1: begin
                  idx_q <= IDX_W'(0);
                  sel_q <= VAL_SAMPLE;
                end
                3'd2: begin
                  idx_q <= IDX_W'(1);
                  sel_q <= VAL_SAMPLE;
                end
                default: begin
                  idx_q <= IDX_W'(2);
                  sel_q <= VAL_SAMPLE;
                  end_q <= 1'b1;
                end
              endcase
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/kdvfv_sweep_top.sv]
// top level of the kdv finite volume sweep: config registers, controller, datapath
// depends on kdvfv_pkg, kdvfv_if, kdvfv_cfg, kdvfv_ctrl, kdvfv_dp

// Usage:
//   in_i carries old grid values, one item per point, in grid order. out_o
//   carries updated points (index, value, end-of-sweep flag). Registers are
//   written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
//   The first four items of a sweep only fill the window and are each taken at
//   once, with no result. Every later item runs seven multiply-accumulate steps
//   on the one shared multiplier plus one rounding step, after which its result
//   is offered; the next item is taken only once its results have been taken.
//   The last item of a sweep gives five results: point N-2, its copy at N-1,
//   and points 0, 1, 2 holding the old last value; the final one carries
//   sweep_end. While out_o is stalled the result and its label hold and no
//   new item is taken. Reset clears position and registers to their defaults;
//   the sample window starts unknown and is not read before four samples fill it.
module kdv_finite_volume_sweep_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  kdvfv_in_if.sink                         in_i,
  kdvfv_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [kdvfv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kdvfv_pkg::DATA_W-1:0]     cfg_data_i
);
  import kdvfv_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // configuration registers
  kdvfv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencing and handshakes
  kdvfv_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_points_i (cfg.grid_points),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .point_index_o (out_o.point_index),
    .sweep_end_o   (out_o.sweep_end),
    .cmd_o         (cmd)
  );

  // arithmetic
  kdvfv_dp u_dp (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .sample_i (in_i.sample),
    .value_o  (out_o.new_value)
  );

endmodule
